// ===== rtl/core/dslr_pkg.sv =====
// Package for the dual servo linear ramp: field widths, compare constants, FSM states.
`timescale 1ns / 1ps
`default_nettype none
package dslr_pkg;

  localparam int unsigned POS_IN_W  = 12;  // target field width
  localparam int unsigned STEP_W    = 6;   // step count / index width
  localparam int unsigned HOLD_W    = 16;  // hold time width
  localparam int unsigned CMP_W     = 12;  // compare field width
  localparam int unsigned IN_DATA_W  = 48; // 46 field bits, padded to bytes
  localparam int unsigned OUT_DATA_W = 48; // 46 field bits, padded to bytes

  localparam logic [CMP_W-1:0] RIGHT_BASE = 12'd500;
  localparam logic [CMP_W-1:0] LEFT_BASE  = 12'd2500;  // 500 + 2000 span

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_OUT
  } state_e;

endpackage
`default_nettype wire

// ===== rtl/core/dual_servo_linear_ramp_unit.sv =====
// Dual servo linear ramp: move requests in, interpolated PWM compare words out.
// Per move: a multiply, then for each interpolation point a load, a bit-serial
// restoring division and an output word; a move of s steps (saturated to MAX_STEPS)
// emits s + 1 words (one if s is 0).
// One move at a time: the input is ready again the cycle after the final word is taken.
// Reset (async, active low): both stored targets clear to zero, the sequencer goes idle.
`timescale 1ns / 1ps
`default_nettype none
module dual_servo_linear_ramp_unit
  import dslr_pkg::*;
#(
  parameter int unsigned MAX_STEPS = 63,  // 1..63, larger step counts saturate here
  parameter int unsigned POS_BITS  = 12   // 8..16, stored target width
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // input word, fields from bit 0 up: target_right[11:0], target_left[11:0],
  // step_count[5:0], hold_ms[15:0], two zero pad bits
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // output word, fields from bit 0 up: right_compare[11:0], left_compare[11:0],
  // step_index[5:0], hold_time[15:0], two zero pad bits
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  output logic                       m_axis_tlast     // last_step
);

  // Numerator num = last * den + delta * i; |num| < 2^(POS_BITS+5), plus headroom.
  localparam int unsigned NUM_W = POS_BITS + 7;
  localparam int unsigned CNT_W = $clog2(NUM_W);
  localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(NUM_W - 1);
  localparam logic [STEP_W-1:0] MAX_S    = STEP_W'(MAX_STEPS);

  state_e state_q, state_d;

  logic in_acc, out_acc;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // input fields
  logic [POS_IN_W-1:0] in_tr, in_tl;
  logic [STEP_W-1:0]   in_steps, steps_sat;
  logic [HOLD_W-1:0]   in_hold;
  logic                in_zero;
  assign in_tr     = s_axis_tdata[11:0];
  assign in_tl     = s_axis_tdata[23:12];
  assign in_steps  = s_axis_tdata[29:24];
  assign in_hold   = s_axis_tdata[45:30];
  assign steps_sat = (in_steps > MAX_S) ? MAX_S : in_steps;
  assign in_zero   = (steps_sat == '0);

  // lane 0 = right arm, lane 1 = left arm
  logic signed [POS_BITS-1:0] tgt [2];
  assign tgt[0] = $signed(POS_BITS'(in_tr));
  assign tgt[1] = $signed(POS_BITS'(in_tl));

  logic signed [POS_BITS-1:0] prev_q [2];   // last target per arm
  logic signed [POS_BITS-1:0] base_q [2];   // ramp start (target itself for a jump)
  logic signed [NUM_W-1:0]    delta_q [2];  // target - last
  logic signed [NUM_W-1:0]    num_q [2];    // running numerator
  logic [NUM_W-1:0]           dvd_q [2];    // dividend in, quotient out, one bit a cycle
  logic [STEP_W-1:0]          rem_q [2];    // partial remainder, below den
  logic [STEP_W-1:0]          den_q;        // divisor: step count, or 1 for a jump
  logic [STEP_W-1:0]          end_q;        // index of the final point
  logic [STEP_W-1:0]          idx_q;
  logic [HOLD_W-1:0]          hold_q;
  logic [CNT_W-1:0]           cnt_q;
  logic [CMP_W-1:0]           right_q, left_q;
  logic                       last_q;

  // one restoring division step per lane
  logic [STEP_W:0]  rem_sh [2];
  logic [STEP_W:0]  rem_nx [2];
  logic             q_bit  [2];
  logic [NUM_W-1:0] quo_nx [2];
  logic [CMP_W-1:0] left_ceil;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      rem_sh[l] = {rem_q[l], dvd_q[l][NUM_W-1]};
      q_bit[l]  = (rem_sh[l] >= {1'b0, den_q});
      rem_nx[l] = q_bit[l] ? (rem_sh[l] - {1'b0, den_q}) : rem_sh[l];
      quo_nx[l] = {dvd_q[l][NUM_W-2:0], q_bit[l]};
    end
    // left side uses the ceiling: bump the quotient on a nonzero remainder
    left_ceil = quo_nx[1][CMP_W-1:0] + CMP_W'(rem_nx[1] != '0);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_MUL;
      ST_MUL:  state_d = ST_LOAD;
      ST_LOAD: state_d = ST_DIV;
      ST_DIV:  if (cnt_q == CNT_LAST) state_d = ST_OUT;
      ST_OUT: begin
        if (out_acc) state_d = last_q ? ST_IDLE : ST_LOAD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_OUT:  m_axis_tvalid = 1'b1;
      default: ;
    endcase
  end

  assign m_axis_tdata = {2'b00, hold_q, idx_q, left_q, right_q};
  assign m_axis_tlast = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      prev_q[0] <= '0;
      prev_q[1] <= '0;
      cnt_q     <= '0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        for (int l = 0; l < 2; l++) prev_q[l] <= tgt[l];
      end
      case (state_q)
        ST_LOAD: cnt_q <= '0;
        ST_DIV:  cnt_q <= cnt_q + CNT_W'(1);
        default: ;
      endcase
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          for (int l = 0; l < 2; l++) begin
            base_q[l]  <= in_zero ? tgt[l] : prev_q[l];
            delta_q[l] <= NUM_W'(tgt[l]) - NUM_W'(prev_q[l]);
          end
          den_q  <= in_zero ? STEP_W'(1) : steps_sat;
          end_q  <= in_zero ? '0 : steps_sat;
          idx_q  <= '0;
          hold_q <= in_hold;
        end
      end
      ST_MUL: begin
        for (int l = 0; l < 2; l++)
          num_q[l] <= NUM_W'(base_q[l]) * $signed(NUM_W'({1'b0, den_q}));
      end
      ST_LOAD: begin
        // a point at or below zero clamps: dividing zero gives floor = ceil = 0
        for (int l = 0; l < 2; l++) begin
          dvd_q[l] <= (num_q[l] > 0) ? NUM_W'(num_q[l]) : '0;
          rem_q[l] <= '0;
        end
      end
      ST_DIV: begin
        for (int l = 0; l < 2; l++) begin
          dvd_q[l] <= quo_nx[l];
          rem_q[l] <= rem_nx[l][STEP_W-1:0];
        end
        if (cnt_q == CNT_LAST) begin
          right_q <= RIGHT_BASE + quo_nx[0][CMP_W-1:0];
          left_q  <= LEFT_BASE - left_ceil;
          last_q  <= (idx_q == end_q);
        end
      end
      ST_OUT: begin
        if (out_acc) begin
          for (int l = 0; l < 2; l++) num_q[l] <= num_q[l] + delta_q[l];
          idx_q <= idx_q + STEP_W'(1);
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/dslr_checker.sv =====
// Port-level checks for the dual servo linear ramp, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module dslr_checker
  import dslr_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  s_axis_tvalid,
  input wire logic                  s_axis_tready,
  input wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic                  m_axis_tlast
);

  // one move at a time: no new request while a word is pending
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready while an output word is pending");

  // a request never produces a word in the next cycle
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid)
    else $error("output word too early after a request");

  // the final word of a move frees the input
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    else $error("input not ready after the final word");

  // a stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled output word changed");

endmodule

bind dual_servo_linear_ramp_unit dslr_checker u_dslr_checker (.*);
`default_nettype wire
